>>> rtl/bed_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bed_pkg: shared types and constants of the backslash escape decoder
// Result and queue entry layouts, decode modes, character codes and the
// lookup for the single-letter escapes.
// ----------------------------------------------------------------------------
package bed_pkg;

  // Decode modes, one-hot
  typedef enum logic [4:0] {
    MODE_NORMAL = 5'b00001,
    MODE_BSLASH = 5'b00010,
    MODE_OCT1   = 5'b00100,
    MODE_OCT2   = 5'b01000,
    MODE_DROP   = 5'b10000
  } mode_t;

  // Character codes
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_STOP      = 8'h63;  // 'c'
  localparam logic [4:0] OCTAL_PREFIX   = 5'b00110;  // '0'..'7' share these bits

  // One decoded result
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    logic       flush_request;
    logic       unknown_warning;
  } result_t;

  // Results caused by one input transfer
  typedef struct packed {
    result_t first;
    result_t second;
    logic    two;
  } entry_t;

  // Escape letter lookup: {hit, control code}
  function automatic logic [8:0] esc_lookup(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      8'h61:   r = {1'b1, 8'h07};  // a
      8'h62:   r = {1'b1, 8'h08};  // b
      8'h66:   r = {1'b1, 8'h0C};  // f
      8'h6E:   r = {1'b1, 8'h0A};  // n
      8'h72:   r = {1'b1, 8'h0D};  // r
      8'h74:   r = {1'b1, 8'h09};  // t
      8'h76:   r = {1'b1, 8'h0B};  // v
      default: r = {1'b0, c};
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/bed_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bed_decode: escape decode state and result logic
// Holds the decode mode, the gathered octal digits and the warning flag,
// and turns each accepted input into zero, one or two results.
// ----------------------------------------------------------------------------
module bed_decode (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [7:0]      text_byte,
  input  wire logic            end_of_text,
  output logic                 push,
  output bed_pkg::entry_t      entry
);

  bed_pkg::mode_t mode, mode_next;
  logic [5:0]     octal_value, octal_value_next;
  logic           warned_once, warned_once_next;

  logic           is_octal;
  logic [2:0]     digit;
  logic [8:0]     esc;
  logic [7:0]     held_byte;

  assign is_octal  = (text_byte[7:3] == bed_pkg::OCTAL_PREFIX);
  assign digit     = text_byte[2:0];
  assign esc       = bed_pkg::esc_lookup(text_byte);
  assign held_byte = {2'b00, octal_value};

  // Decode one input against the current mode
  always_comb begin
    mode_next        = mode;
    octal_value_next = octal_value;
    warned_once_next = warned_once;
    push             = 1'b0;
    entry            = '0;

    if (end_of_text) begin
      mode_next        = bed_pkg::MODE_NORMAL;
      octal_value_next = '0;
      case (mode)
        bed_pkg::MODE_BSLASH: begin
          push                      = 1'b1;
          entry.first.out_byte      = bed_pkg::CHAR_BACKSLASH;
          entry.first.byte_valid    = 1'b1;
          entry.first.string_done   = 1'b1;
        end
        bed_pkg::MODE_OCT1, bed_pkg::MODE_OCT2: begin
          push                      = 1'b1;
          entry.first.out_byte      = held_byte;
          entry.first.byte_valid    = 1'b1;
          entry.first.string_done   = 1'b1;
        end
        bed_pkg::MODE_DROP: begin
          push = 1'b0;
        end
        default: begin
          push                      = 1'b1;
          entry.first.string_done   = 1'b1;
        end
      endcase
    end else begin
      case (mode)
        bed_pkg::MODE_BSLASH: begin
          if (text_byte == bed_pkg::CHAR_STOP) begin
            push                      = 1'b1;
            entry.first.string_done   = 1'b1;
            entry.first.flush_request = 1'b1;
            mode_next                 = bed_pkg::MODE_DROP;
          end else if (is_octal) begin
            octal_value_next = {3'b000, digit};
            mode_next        = bed_pkg::MODE_OCT1;
          end else if (esc[8]) begin
            push                   = 1'b1;
            entry.first.out_byte   = esc[7:0];
            entry.first.byte_valid = 1'b1;
            mode_next              = bed_pkg::MODE_NORMAL;
          end else begin
            push                        = 1'b1;
            entry.first.out_byte        = text_byte;
            entry.first.byte_valid      = 1'b1;
            entry.first.unknown_warning = ~warned_once;
            warned_once_next            = 1'b1;
            mode_next                   = bed_pkg::MODE_NORMAL;
          end
        end
        bed_pkg::MODE_OCT1, bed_pkg::MODE_OCT2: begin
          if (is_octal && mode == bed_pkg::MODE_OCT1) begin
            octal_value_next = {octal_value[2:0], digit};
            mode_next        = bed_pkg::MODE_OCT2;
          end else if (is_octal) begin
            // third digit completes the escape, keep the low 8 bits
            push                   = 1'b1;
            entry.first.out_byte   = {octal_value[4:0], digit};
            entry.first.byte_valid = 1'b1;
            octal_value_next       = '0;
            mode_next              = bed_pkg::MODE_NORMAL;
          end else begin
            // emit the pending value, then treat the byte as plain text
            push                   = 1'b1;
            entry.first.out_byte   = held_byte;
            entry.first.byte_valid = 1'b1;
            octal_value_next       = '0;
            if (text_byte == bed_pkg::CHAR_BACKSLASH) begin
              mode_next = bed_pkg::MODE_BSLASH;
            end else begin
              entry.two               = 1'b1;
              entry.second.out_byte   = text_byte;
              entry.second.byte_valid = 1'b1;
              mode_next               = bed_pkg::MODE_NORMAL;
            end
          end
        end
        bed_pkg::MODE_DROP: begin
          push = 1'b0;
        end
        default: begin
          if (text_byte == bed_pkg::CHAR_BACKSLASH) begin
            mode_next = bed_pkg::MODE_BSLASH;
          end else begin
            push                   = 1'b1;
            entry.first.out_byte   = text_byte;
            entry.first.byte_valid = 1'b1;
            mode_next              = bed_pkg::MODE_NORMAL;
          end
        end
      endcase
    end
  end

  // Advance state on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= bed_pkg::MODE_NORMAL;
      octal_value <= '0;
      warned_once <= 1'b0;
    end else if (accept) begin
      mode        <= mode_next;
      octal_value <= octal_value_next;
      warned_once <= warned_once_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/bed_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bed_queue: two-entry result queue
// Each entry holds the one or two results of one input transfer and is
// drained one result per output transfer.
// ----------------------------------------------------------------------------
module bed_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire bed_pkg::entry_t push_entry,
  output logic                 full,
  output logic                 result_valid,
  input  wire logic            result_stall,
  output bed_pkg::result_t     result,
  output logic                 last_of_run
);

  bed_pkg::entry_t entries [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count, count_next;
  logic            sub;
  logic            pop_sub;
  logic            pop_entry;
  bed_pkg::entry_t head;

  assign head         = entries[rd_ptr];
  assign result_valid = (count != 2'd0);
  assign full         = (count == 2'd2);
  assign pop_sub      = result_valid & ~result_stall;
  assign last_of_run  = ~head.two | sub;
  assign pop_entry    = pop_sub & last_of_run;
  assign result       = sub ? head.second : head.first;

  always_comb begin
    count_next = count;
    case ({push, pop_entry})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  // Store a new entry
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers, fill count and the result select within an entry
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
      sub    <= 1'b0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_entry) begin
        rd_ptr <= ~rd_ptr;
        sub    <= 1'b0;
      end else if (pop_sub) begin
        sub <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/backslash_escape_decoder_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// backslash_escape_decoder_top: C-style backslash escape decoder
// Expands backslash escapes in a byte stream, one byte per cycle while not stalled.
// ----------------------------------------------------------------------------
// The block takes one text byte (or an end-of-text mark) per cycle unless stalled
// and decodes it in a single pass against the registered escape state; the
// results go into a two-entry queue in front of the output port. Most
// inputs give zero or one result, and such inputs sustain one per cycle while
// the output is not stalled. An octal escape ended by a plain byte gives two
// results (the octal value, then the byte); these leave one per output transfer,
// and the input is stalled while the queue holds two entries. Each result is
// written into the queue register before it reaches the output; last_of_run
// marks the final result of each input.
// ----------------------------------------------------------------------------
module backslash_escape_decoder_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       text_valid,
  output logic            text_stall,
  input  wire logic [7:0] text_byte,
  input  wire logic       end_of_text,
  output logic            result_valid,
  input  wire logic       result_stall,
  output logic [7:0]      out_byte,
  output logic            byte_valid,
  output logic            string_done,
  output logic            flush_request,
  output logic            unknown_warning,
  output logic            last_of_run
);

  logic             accept;
  logic             push;
  logic             full;
  bed_pkg::entry_t  entry;
  bed_pkg::result_t result;

  // Input transfer
  assign text_stall = full;
  assign accept     = text_valid & ~text_stall;

  bed_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .push        (push),
    .entry       (entry)
  );

  bed_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (accept & push),
    .push_entry   (entry),
    .full         (full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .last_of_run  (last_of_run)
  );

  // Unpack the head result onto the ports
  assign out_byte        = result.out_byte;
  assign byte_valid      = result.byte_valid;
  assign string_done     = result.string_done;
  assign flush_request   = result.flush_request;
  assign unknown_warning = result.unknown_warning;

  // A flush result ends the string and carries no byte
  a_flush_shape: assert property (@(posedge clk) disable iff (rst)
    result_valid && flush_request |-> string_done && !byte_valid)
    else $error("flush result carries a byte or lacks string_done");

  // The input is only held off while results are waiting
  a_stall_pending: assert property (@(posedge clk) disable iff (rst)
    text_stall |-> result_valid)
    else $error("input stalled with an empty result queue");

  // A warning only comes with an emitted byte
  a_warn_byte: assert property (@(posedge clk) disable iff (rst)
    result_valid && unknown_warning |-> byte_valid && !string_done)
    else $error("unknown escape warning without a byte");

  // The first of two results is always a plain octal byte
  a_first_of_two: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_of_run |-> byte_valid && !string_done && !flush_request)
    else $error("first of two results is not an octal byte");

endmodule
`default_nettype wire

>>> dv/backslash_escape_decoder_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// backslash_escape_decoder_top_tb: self-checking bench for the escape decoder
// Drives a short table of hand-picked bytes, then random escape sequences
// mixed with noise. A behavioral decoder predicts each result or a table row
// pins it; each result transfer is checked field by field against the oldest one.
// ----------------------------------------------------------------------------
module backslash_escape_decoder_top_tb;

  // Control codes of the single-letter escapes
  localparam logic [7:0] CODE_BEL = 8'h07;
  localparam logic [7:0] CODE_BS  = 8'h08;
  localparam logic [7:0] CODE_HT  = 8'h09;
  localparam logic [7:0] CODE_LF  = 8'h0A;
  localparam logic [7:0] CODE_VT  = 8'h0B;
  localparam logic [7:0] CODE_FF  = 8'h0C;
  localparam logic [7:0] CODE_CR  = 8'h0D;

  localparam int RANDOM_ITEMS = 1800;
  localparam int CALM_AFTER   = 1500;
  localparam int NUM_ROWS     = 28;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    logic       flush_request;
    logic       unknown_warning;
    logic       last_of_run;
  } dec_result_t;

  // One directed row: input byte, end mark, and an optional typed-in result
  typedef struct packed {
    logic [7:0]  text;
    logic        eot;
    logic        pinned;
    dec_result_t want;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       text_valid = 1'b0;
  logic       text_stall;
  logic [7:0] text_byte = 8'h00;
  logic       end_of_text = 1'b0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       string_done;
  logic       flush_request;
  logic       unknown_warning;
  logic       last_of_run;

  // Predictor state
  bed_pkg::mode_t dec_mode = bed_pkg::MODE_NORMAL;
  logic [8:0]     oct_acc = '0;
  logic           warn_seen = 1'b0;

  dec_result_t pending_results [$];
  int          mismatches = 0;
  int          items_sent = 0;
  bit          calm = 1'b0;
  dec_result_t got, want;

  stim_row_t stim_table [NUM_ROWS] = '{
    '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1}},  // end of text after reset
    '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1}},  // zero byte passes
    '{8'hFF, 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{bed_pkg::CHAR_BACKSLASH, 1'b0, 1'b0, '0},
    '{"z", 1'b0, 1'b1, '{"z", 1'b1, 1'b0, 1'b0, 1'b1, 1'b1}},      // first unknown warns
    '{bed_pkg::CHAR_BACKSLASH, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1}},  // unknown, no repeat warn
    '{bed_pkg::CHAR_BACKSLASH, 1'b0, 1'b0, '0},
    '{"n", 1'b0, 1'b0, '0},
    '{bed_pkg::CHAR_BACKSLASH, 1'b0, 1'b0, '0},
    '{"3", 1'b0, 1'b0, '0},
    '{"7", 1'b0, 1'b0, '0},
    '{"7", 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1}},    // largest octal
    '{bed_pkg::CHAR_BACKSLASH, 1'b0, 1'b0, '0},
    '{"7", 1'b0, 1'b0, '0},
    '{"x", 1'b0, 1'b0, '0},                                        // octal then plain byte
    '{bed_pkg::CHAR_BACKSLASH, 1'b0, 1'b0, '0},
    '{"1", 1'b0, 1'b0, '0},
    '{bed_pkg::CHAR_BACKSLASH, 1'b0, 1'b0, '0},                    // octal ended by backslash
    '{8'h00, 1'b1, 1'b0, '0},                                      // lone backslash at end
    '{bed_pkg::CHAR_BACKSLASH, 1'b0, 1'b0, '0},
    '{"4", 1'b0, 1'b0, '0},
    '{"5", 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b0, '0},                                      // octal pending at end
    '{bed_pkg::CHAR_BACKSLASH, 1'b0, 1'b0, '0},
    '{bed_pkg::CHAR_STOP, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1}},
    '{"q", 1'b0, 1'b0, '0},                                        // dropped
    '{8'hFF, 1'b1, 1'b0, '0}                                       // silent end
  };

  logic [7:0] esc_letters [7] = '{"a", "b", "f", "n", "r", "t", "v"};

  backslash_escape_decoder_top u_top (
    .clk            (clk),
    .rst            (rst),
    .text_valid     (text_valid),
    .text_stall     (text_stall),
    .text_byte      (text_byte),
    .end_of_text    (end_of_text),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .out_byte       (out_byte),
    .byte_valid     (byte_valid),
    .string_done    (string_done),
    .flush_request  (flush_request),
    .unknown_warning(unknown_warning),
    .last_of_run    (last_of_run)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hard stop in case the pipeline hangs
  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic dec_result_t make_result(input logic [7:0] b, input logic v,
                                              input logic d, input logic f,
                                              input logic w);
    dec_result_t r;
    r.out_byte        = v ? b : 8'h00;
    r.byte_valid      = v;
    r.string_done     = d;
    r.flush_request   = f;
    r.unknown_warning = w;
    r.last_of_run     = 1'b0;
    return r;
  endfunction

  // Advance the decoder model by one transfer and return what it emits
  task automatic decode_step(input logic [7:0] c, input logic eot,
                             output dec_result_t r0, output dec_result_t r1,
                             output int n);
    dec_result_t res [2];
    logic [7:0]  ctrl;
    logic        ctrl_hit;
    logic        is_digit;
    logic        pass_on;
    res[0]   = '0;
    res[1]   = '0;
    n        = 0;
    pass_on  = 1'b0;
    is_digit = (c[7:3] == bed_pkg::OCTAL_PREFIX);
    ctrl_hit = 1'b1;
    ctrl     = c;
    case (c)
      "a":     ctrl = CODE_BEL;
      "b":     ctrl = CODE_BS;
      "f":     ctrl = CODE_FF;
      "n":     ctrl = CODE_LF;
      "r":     ctrl = CODE_CR;
      "t":     ctrl = CODE_HT;
      "v":     ctrl = CODE_VT;
      default: ctrl_hit = 1'b0;
    endcase

    if (eot) begin
      case (dec_mode)
        bed_pkg::MODE_BSLASH: begin
          res[0] = make_result(bed_pkg::CHAR_BACKSLASH, 1'b1, 1'b1, 1'b0, 1'b0);
          n = 1;
        end
        bed_pkg::MODE_OCT1, bed_pkg::MODE_OCT2: begin
          res[0] = make_result(oct_acc[7:0], 1'b1, 1'b1, 1'b0, 1'b0);
          n = 1;
        end
        bed_pkg::MODE_DROP: ;
        default: begin
          res[0] = make_result(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
          n = 1;
        end
      endcase
      dec_mode = bed_pkg::MODE_NORMAL;
      oct_acc  = '0;
    end else begin
      case (dec_mode)
        bed_pkg::MODE_BSLASH: begin
          if (c == bed_pkg::CHAR_STOP) begin
            res[0]   = make_result(8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
            n        = 1;
            dec_mode = bed_pkg::MODE_DROP;
          end else if (is_digit) begin
            oct_acc  = {6'd0, c[2:0]};
            dec_mode = bed_pkg::MODE_OCT1;
          end else if (ctrl_hit) begin
            res[0]   = make_result(ctrl, 1'b1, 1'b0, 1'b0, 1'b0);
            n        = 1;
            dec_mode = bed_pkg::MODE_NORMAL;
          end else begin
            res[0]    = make_result(c, 1'b1, 1'b0, 1'b0, !warn_seen);
            n         = 1;
            warn_seen = 1'b1;
            dec_mode  = bed_pkg::MODE_NORMAL;
          end
        end
        bed_pkg::MODE_OCT1: begin
          if (is_digit) begin
            oct_acc  = {oct_acc[5:0], c[2:0]};
            dec_mode = bed_pkg::MODE_OCT2;
          end else begin
            res[0]  = make_result(oct_acc[7:0], 1'b1, 1'b0, 1'b0, 1'b0);
            n       = 1;
            oct_acc = '0;
            pass_on = 1'b1;
          end
        end
        bed_pkg::MODE_OCT2: begin
          if (is_digit) begin
            res[0]   = make_result({oct_acc[4:0], c[2:0]}, 1'b1, 1'b0, 1'b0, 1'b0);
            n        = 1;
            oct_acc  = '0;
            dec_mode = bed_pkg::MODE_NORMAL;
          end else begin
            res[0]  = make_result(oct_acc[7:0], 1'b1, 1'b0, 1'b0, 1'b0);
            n       = 1;
            oct_acc = '0;
            pass_on = 1'b1;
          end
        end
        bed_pkg::MODE_DROP: ;
        default: pass_on = 1'b1;
      endcase

      // Handle the byte as plain text
      if (pass_on) begin
        if (c == bed_pkg::CHAR_BACKSLASH) begin
          dec_mode = bed_pkg::MODE_BSLASH;
        end else begin
          res[n]   = make_result(c, 1'b1, 1'b0, 1'b0, 1'b0);
          n        = n + 1;
          dec_mode = bed_pkg::MODE_NORMAL;
        end
      end
    end

    if (n > 0) res[n-1].last_of_run = 1'b1;
    r0 = res[0];
    r1 = res[1];
  endtask

  // Send one byte; called and returns at a falling edge
  task automatic send_item(input logic [7:0] c, input logic eot,
                           input logic pinned, input dec_result_t pin_want);
    dec_result_t r0, r1;
    int          n;
    if (!calm && ((items_sent / 120) % 4) != 3 && $urandom_range(0, 5) == 0) begin
      text_valid  = 1'b0;
      text_byte   = 8'($urandom);
      end_of_text = 1'($urandom);
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    text_valid  = 1'b1;
    text_byte   = c;
    end_of_text = eot;
    do @(posedge clk); while (text_stall);

    // Transfer taken: predict it
    if (dec_mode != bed_pkg::MODE_DROP) items_sent++;
    decode_step(c, eot, r0, r1, n);
    if (pinned) begin
      pending_results.push_back(pin_want);
    end else begin
      if (n > 0) pending_results.push_back(r0);
      if (n > 1) pending_results.push_back(r1);
    end
    @(negedge clk);
  endtask

  task automatic report_field(input string fld, input logic [7:0] exp_v,
                              input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t ns: %s expected %02h actual %02h", $time, fld, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Check each result transfer against the oldest prediction
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      got = '{out_byte, byte_valid, string_done, flush_request, unknown_warning,
              last_of_run};
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result expected none actual %p", $time, got);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        report_field("out_byte", want.out_byte, got.out_byte);
        report_field("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
        report_field("string_done", 8'(want.string_done), 8'(got.string_done));
        report_field("flush_request", 8'(want.flush_request), 8'(got.flush_request));
        report_field("unknown_warning", 8'(want.unknown_warning),
                     8'(got.unknown_warning));
        report_field("last_of_run", 8'(want.last_of_run), 8'(got.last_of_run));
      end
    end
  end

  // Stall the result side in bursts, with quiet stretches
  initial begin
    int cyc;
    cyc = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (!calm && !rst && (cyc % 500) < 380 && $urandom_range(0, 7) == 0) begin
        result_stall = 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        result_stall = 1'b0;
      end
    end
  end

  initial begin
    int         kind;
    int         guard;
    logic [7:0] pick;
    bit         drained;
    drained = 1'b0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Directed table
    for (int i = 0; i < NUM_ROWS; i++) begin
      send_item(stim_table[i].text, stim_table[i].eot, stim_table[i].pinned,
                stim_table[i].want);
    end
    text_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    items_sent = 0;

    // Random sequences, mostly well formed
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent >= CALM_AFTER) calm = 1'b1;
      // Hold the sender once until the output side drains
      if (!drained && items_sent >= 900) begin
        text_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        drained = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 28) begin
        do pick = 8'($urandom); while (pick == bed_pkg::CHAR_BACKSLASH);
        send_item(pick, 1'b0, 1'b0, '0);
      end else if (kind < 42) begin
        send_item(bed_pkg::CHAR_BACKSLASH, 1'b0, 1'b0, '0);
        send_item(esc_letters[$urandom_range(0, 6)], 1'b0, 1'b0, '0);
      end else if (kind < 62) begin
        send_item(bed_pkg::CHAR_BACKSLASH, 1'b0, 1'b0, '0);
        repeat ($urandom_range(1, 3)) begin
          send_item({bed_pkg::OCTAL_PREFIX, 3'($urandom)}, 1'b0, 1'b0, '0);
        end
        if ($urandom_range(0, 3) == 0) send_item(8'($urandom), 1'b1, 1'b0, '0);
      end else if (kind < 70) begin
        send_item(bed_pkg::CHAR_BACKSLASH, 1'b0, 1'b0, '0);
        send_item(8'($urandom), 1'b0, 1'b0, '0);
      end else if (kind < 76) begin
        send_item(bed_pkg::CHAR_BACKSLASH, 1'b0, 1'b0, '0);
        send_item(bed_pkg::CHAR_STOP, 1'b0, 1'b0, '0);
        repeat ($urandom_range(0, 3)) send_item(8'($urandom), 1'b0, 1'b0, '0);
        send_item(8'($urandom), 1'b1, 1'b0, '0);
      end else if (kind < 84) begin
        send_item(8'($urandom), 1'b1, 1'b0, '0);
      end else if (kind < 88) begin
        send_item(bed_pkg::CHAR_BACKSLASH, 1'b0, 1'b0, '0);
        send_item(8'($urandom), 1'b1, 1'b0, '0);
      end else begin
        send_item(8'($urandom), ($urandom_range(0, 7) == 0), 1'b0, '0);
      end
    end
    text_valid = 1'b0;

    // Drain, then allow time for stray results
    guard = 0;
    while (pending_results.size() != 0 && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (10) @(negedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t ns: %0d results never arrived", $time, pending_results.size());
    end
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> backslash_escape_decoder_top.f
rtl/bed_pkg.sv
rtl/bed_decode.sv
rtl/bed_queue.sv
rtl/backslash_escape_decoder_top.sv
dv/backslash_escape_decoder_top_tb.sv
